/* rtl/ita_pkg.sv */
// Shared types, constants and the digit-to-ASCII function for the integer formatter.
// No dependencies.
package ita_pkg;

	localparam int NUM_CELLS  = 10;  // decimal digits of a 32-bit word
	localparam int HEX_CELLS  = 8;   // nibbles of a 32-bit word
	localparam int CONV_STEPS = 32;  // one double-dabble step per input bit

	localparam logic [1:0] MODE_SIGNED   = 2'd0;
	localparam logic [1:0] MODE_UNSIGNED = 2'd1;
	localparam logic [1:0] MODE_HEX      = 2'd2;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_UPPER = 8'h41;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] DEC_BASE   = 8'd10;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_LOAD   = 2'd1,
		CELL_DABBLE = 2'd2,
		CELL_MOVE   = 2'd3
	} cell_op_t;

	function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
		logic [7:0] d8;
		d8 = {4'b0000, d};
		if (d8 < DEC_BASE)
			return CHAR_ZERO + d8;
		return CHAR_UPPER + d8 - DEC_BASE;
	endfunction

endpackage

/* rtl/ita_cell.sv */
// One digit cell of the conversion chain: double-dabble step, load, move up, or hold.
// Depends on ita_pkg.
module ita_cell (
	input  logic               clk,
	input  ita_pkg::cell_op_t  op,
	input  logic [3:0]         load_digit,
	input  logic               bit_in,
	input  logic [3:0]         digit_below,
	output logic               carry_out,
	output logic [3:0]         digit
);

	logic [3:0] digit_q;
	logic [3:0] adj;

	// add three before the shift so the digit stays decimal after doubling
	always_comb begin
		adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	end

	assign carry_out = adj[3];
	assign digit     = digit_q;

	always_ff @(posedge clk) begin
		unique case (op)
			ita_pkg::CELL_HOLD:   digit_q <= digit_q;
			ita_pkg::CELL_LOAD:   digit_q <= load_digit;
			ita_pkg::CELL_DABBLE: digit_q <= {adj[2:0], bit_in};
			ita_pkg::CELL_MOVE:   digit_q <= digit_below;
			default:              digit_q <= digit_q;
		endcase
	end

endmodule

/* rtl/int_to_ascii_formatter.sv */
// In signed mode a negative value gives '-' first, sent while the digits are still being
// formed; decimal digits follow with leading zeros skipped; hex skips leading zeros too.
// A decimal item takes 32 dabble steps in the cell chain plus 10 digit shifts out of the
// top cell, a hex item 8 nibble shifts; a new item is taken only once busy has dropped.
// Reset clears the sequencer and the result strobe; digit cells are not reset.
// The receiver cannot stall: each character is shown for exactly one cycle.
module int_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [31:0] value,
	output logic        valid,
	output logic [7:0]  character,
	output logic        last
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CONV = 3'b010,
		S_EMIT = 3'b100
	} state_t;

	state_t            state_q;
	logic [31:0]       mag_q;
	logic [4:0]        cnt_q;
	logic [3:0]        rem_q;
	logic              neg_q;
	logic              started_q;
	logic              valid_q;
	logic [7:0]        char_q;
	logic              last_q;

	ita_pkg::cell_op_t op;
	logic              accept;
	logic              is_hex;
	logic              is_neg;
	logic [31:0]       mag_in;
	logic [3:0]        top;
	logic              emit;

	logic [3:0] digit_w [ita_pkg::NUM_CELLS];
	logic       carry_w [ita_pkg::NUM_CELLS];

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign is_hex = action[1];
	assign is_neg = (action == ita_pkg::MODE_SIGNED) && value[31];
	assign mag_in = is_neg ? (32'd0 - value) : value;
	assign top    = digit_w[ita_pkg::NUM_CELLS-1];
	assign emit   = started_q || (top != 4'd0) || (rem_q == 4'd1);

	always_comb begin
		unique case (state_q)
			S_IDLE:  op = accept ? ita_pkg::CELL_LOAD : ita_pkg::CELL_HOLD;
			S_CONV:  op = ita_pkg::CELL_DABBLE;
			S_EMIT:  op = ita_pkg::CELL_MOVE;
			default: op = ita_pkg::CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < ita_pkg::NUM_CELLS; i++) begin : g_cell
		logic [3:0] load_d;
		logic       bin;
		logic [3:0] below;

		// hex nibbles sit in the top cells, most significant nibble at the top
		if (i >= ita_pkg::NUM_CELLS - ita_pkg::HEX_CELLS) begin : g_nib
			assign load_d = is_hex ?
				value[4*(i-(ita_pkg::NUM_CELLS-ita_pkg::HEX_CELLS)) +: 4] : 4'd0;
		end else begin : g_nonib
			assign load_d = 4'd0;
		end

		if (i == 0) begin : g_first
			assign bin   = mag_q[31];
			assign below = 4'd0;
		end else begin : g_rest
			assign bin   = carry_w[i-1];
			assign below = digit_w[i-1];
		end

		ita_cell u_cell (
			.clk        (clk),
			.op         (op),
			.load_digit (load_d),
			.bit_in     (bin),
			.digit_below(below),
			.carry_out  (carry_w[i]),
			.digit      (digit_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= 5'd0;
			rem_q     <= 4'd0;
			neg_q     <= 1'b0;
			started_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					valid_q <= 1'b0;
					if (accept) begin
						cnt_q     <= 5'd0;
						neg_q     <= is_neg;
						started_q <= 1'b0;
						if (is_hex) begin
							state_q <= S_EMIT;
							rem_q   <= 4'(ita_pkg::HEX_CELLS);
						end else begin
							state_q <= S_CONV;
						end
					end
				end
				S_CONV: begin
					// the sign goes out while the digits are still being formed
					valid_q <= neg_q;
					if (neg_q) begin
						neg_q <= 1'b0;
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(ita_pkg::CONV_STEPS - 1)) begin
						state_q <= S_EMIT;
						rem_q   <= 4'(ita_pkg::NUM_CELLS);
					end
				end
				S_EMIT: begin
					rem_q   <= rem_q - 4'd1;
					valid_q <= emit;
					if (emit) begin
						started_q <= 1'b1;
					end
					if (rem_q == 4'd1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					valid_q <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CONV) begin
			mag_q  <= {mag_q[30:0], 1'b0};
			char_q <= ita_pkg::CHAR_MINUS;
			last_q <= 1'b0;
		end else if (state_q == S_EMIT) begin
			char_q <= ita_pkg::digit_to_ascii(top);
			last_q <= (rem_q == 4'd1);
		end else if (accept) begin
			mag_q <= mag_in;
		end
	end

	assign valid     = valid_q;
	assign character = char_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid)
		else $error("beat follows the final character directly");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |-> busy)
		else $error("non-final character while idle");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == S_EMIT && rem_q == 4'd0))
		else $error("emit phase with no positions left");
`endif

endmodule
